[design/tmrs_pkg.sv]
// Shared types and codes for the trackball motion, rotate and scroll block.
// No dependencies; used by the channel interface users and the top level.
`timescale 1ns / 1ps
`default_nettype none
package tmrs_pkg;

  // request codes
  localparam logic [1:0] REQ_MOTION  = 2'd0;
  localparam logic [1:0] REQ_PRESS   = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_COS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_SIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_DIV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_V    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTV   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAG_TOGGLE = 3'd5;
  localparam int unsigned CFG_DATA_W = 16;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [15:0]        now_ms;
  } req_t;

  typedef struct packed {
    logic signed [7:0] cur_x;
    logic signed [7:0] cur_y;
    logic signed [7:0] wheel_v;
    logic signed [7:0] wheel_h;
    logic              active;
    logic              drag_on;
  } rsp_t;

endpackage
`default_nettype wire

[design/tmrs_chan_if.sv]
// Valid/ready channel carrying one word of payload type T.
// Standalone; payload types come from tmrs_pkg at the point of use.
`timescale 1ns / 1ps
`default_nettype none
interface tmrs_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/trackball_motion_rotate_scroll_top.sv]
// Trackball motion block: accumulate, gate, rotate, cursor or drag scroll.
// Uses tmrs_pkg and tmrs_chan_if.
// Drag/clear items go straight to the result; gated or idle motion stops at
//   the gate; drag motion runs two 7-step quotient loops plus the shared
//   32x16 multiplier twice.
// Throughput: one word in flight; the next is taken after the result leaves.
// Reset (rst, synchronous): config to defaults, accumulators, remainders,
//   drag flag and poll timestamp to zero.
`timescale 1ns / 1ps
`default_nettype none
module trackball_motion_rotate_scroll_top #(
  parameter int ACC_FRAC_BITS  = 8,
  parameter int COEF_FRAC_BITS = 14
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  tmrs_chan_if.sink                            in_ch,
  tmrs_chan_if.source                          out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [tmrs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [tmrs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tmrs_pkg::*;

  localparam int PW = 48;            // multiplier product
  localparam int RW = PW + 1;        // rotated sums
  localparam int SW = RW + 2;        // saturation input
  localparam int DW = 8 + ACC_FRAC_BITS;   // fixed-point divisor
  localparam int NW = RW + 2;        // divider numerator

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GATE  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_POST  = 4'd3;
  localparam logic [3:0] S_FIX   = 4'd4;
  localparam logic [3:0] S_DLOAD = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_REM   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam logic [1:0] PH_ROT  = 2'd0;
  localparam logic [1:0] PH_BACK = 2'd1;
  localparam logic [1:0] PH_REM  = 2'd2;

  // helpers
  function automatic logic signed [RW-1:0] rnd_pow2(input logic signed [RW-1:0] v,
                                                    input int k);
    logic [RW:0] mag;
    logic [RW:0] q;
    begin
      mag = v[RW-1] ? (RW+1)'(-$signed({v[RW-1], v})) : (RW+1)'({1'b0, v});
      q = (mag + ((RW+1)'(1) << (k - 1))) >> k;
      rnd_pow2 = v[RW-1] ? -$signed(q[RW-1:0]) : $signed(q[RW-1:0]);
    end
  endfunction

  function automatic logic signed [7:0] clamp127(input logic signed [RW-1:0] v);
    begin
      if (v > RW'(127)) clamp127 = 8'sd127;
      else if (v < -RW'(127)) clamp127 = -8'sd127;
      else clamp127 = v[7:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    begin
      if (v > SW'(32'sh7fffffff)) sat32 = 32'sh7fffffff;
      else if (v < SW'(-33'sh80000000)) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

  // configuration
  logic signed [15:0] rot_cos, rot_sin;
  logic [7:0]         scroll_div, poll_interval;
  logic               invert_v, drag_toggle;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_cos       <= 16'sd16384;
      rot_sin       <= 16'sd0;
      scroll_div    <= 8'd8;
      invert_v      <= 1'b0;
      poll_interval <= 8'd1;
      drag_toggle   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ROT_COS:     rot_cos       <= cfg_wdata;
        CFG_ROT_SIN:     rot_sin       <= cfg_wdata;
        CFG_SCROLL_DIV:  scroll_div    <= cfg_wdata[7:0];
        CFG_INVERT_V:    invert_v      <= cfg_wdata[0];
        CFG_POLL_INTV:   poll_interval <= cfg_wdata[7:0];
        CFG_DRAG_TOGGLE: drag_toggle   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // state
  logic [3:0]         state;
  logic [1:0]         phase, cnt;
  logic signed [31:0] acc_x, acc_y, rem_x, rem_y;
  logic               drag_active;
  logic [15:0]        last_poll, now_q;
  logic signed [PW-1:0] prod [4];
  logic signed [7:0]  sx, sy, sv, sh;
  logic signed [RW-1:0] tx, ty;
  logic               act;
  logic               div_sel, dneg, big;
  logic [NW-1:0]      num, dd;
  logic [6:0]         quo;
  logic [2:0]         dcnt;
  rsp_t               rsp;

  // drag flag after the incoming word
  logic drag_next;
  always_comb begin
    drag_next = drag_active;
    case (in_ch.data.req_type)
      REQ_PRESS:   drag_next = drag_toggle ? ~drag_active : 1'b1;
      REQ_RELEASE: drag_next = drag_toggle & drag_active;
      REQ_CLEAR:   drag_next = 1'b0;
      default:     drag_next = drag_active;
    endcase
  end

  // result word loaded at accept: all zero but the drag flag
  rsp_t rsp_idle;
  always_comb begin
    rsp_idle = '0;
    rsp_idle.drag_on = drag_next;
  end

  // fixed-point divisor, zero acts as one
  logic [DW-1:0] dfix;
  assign dfix = (scroll_div == 8'd0) ? DW'(1) << ACC_FRAC_BITS
                                     : DW'(scroll_div) << ACC_FRAC_BITS;

  logic signed [7:0] senty;
  assign senty = invert_v ? sv : -sv;

  // shared multiplier operand select
  logic signed [31:0] mul_a;
  logic signed [15:0] mul_b;
  always_comb begin
    mul_a = acc_x;
    mul_b = rot_cos;
    case (phase)
      PH_ROT: begin
        case (cnt)
          2'd0: begin mul_a = acc_x; mul_b = rot_cos; end
          2'd1: begin mul_a = acc_y; mul_b = rot_sin; end
          2'd2: begin mul_a = acc_x; mul_b = rot_sin; end
          default: begin mul_a = acc_y; mul_b = rot_cos; end
        endcase
      end
      PH_BACK: begin
        case (cnt)
          2'd0: begin mul_a = 32'(sx); mul_b = rot_cos; end
          2'd1: begin mul_a = 32'(sy); mul_b = rot_sin; end
          2'd2: begin mul_a = 32'(sy); mul_b = rot_cos; end
          default: begin mul_a = 32'(sx); mul_b = rot_sin; end
        endcase
      end
      default: begin
        mul_a = $signed(32'(dfix));
        mul_b = (cnt == 2'd0) ? 16'(senty) : 16'(sh);
      end
    endcase
  end

  logic signed [PW-1:0] mul_p;
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // combinational values for the step logic
  logic signed [31:0] one32;
  assign one32 = 32'sd1 <<< ACC_FRAC_BITS;

  logic signed [31:0] acc_x_add, acc_y_add;
  assign acc_x_add = sat32(SW'(acc_x) + (SW'(in_ch.data.dx) <<< ACC_FRAC_BITS));
  assign acc_y_add = sat32(SW'(acc_y) + (SW'(in_ch.data.dy) <<< ACC_FRAC_BITS));

  logic [15:0] elapsed;
  assign elapsed = now_q - last_poll;

  logic signed [RW-1:0] rx, ry, bx, by;
  assign rx = RW'(prod[0]) - RW'(prod[1]);
  assign ry = RW'(prod[2]) + RW'(prod[3]);
  assign bx = (RW'(prod[0]) + RW'(prod[1])) <<< ACC_FRAC_BITS;
  assign by = (RW'(prod[2]) - RW'(prod[3])) <<< ACC_FRAC_BITS;

  // divider load values
  logic signed [RW-1:0] dsrc;
  logic [RW:0]          dmag;
  logic [NW-1:0]        d2, nload;
  assign dsrc  = div_sel ? tx : (invert_v ? ty : -ty);
  assign dmag  = dsrc[RW-1] ? (RW+1)'(-$signed({dsrc[RW-1], dsrc}))
                            : (RW+1)'({1'b0, dsrc});
  assign d2    = NW'(dfix) << 1;
  assign nload = (NW'(dmag) << 1) + NW'(dfix);

  logic          dbit;
  logic [6:0]    quo_n, quo_f;
  logic signed [7:0] dres;
  assign dbit  = (num >= dd);
  assign quo_n = quo | (dbit ? (7'd1 << dcnt) : 7'd0);
  assign quo_f = big ? 7'd127 : quo_n;
  assign dres  = dneg ? -$signed({1'b0, quo_f}) : $signed({1'b0, quo_f});

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = rsp;

  // multiplier product register
  always_ff @(posedge clk) begin
    if (state == S_MUL) prod[cnt] <= mul_p;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_ROT;
      cnt         <= 2'd0;
      acc_x       <= '0;
      acc_y       <= '0;
      rem_x       <= '0;
      rem_y       <= '0;
      drag_active <= 1'b0;
      last_poll   <= '0;
      div_sel     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            rsp   <= rsp_idle;
            now_q <= in_ch.data.now_ms;
            case (in_ch.data.req_type)
              REQ_MOTION: begin
                acc_x <= acc_x_add;
                acc_y <= acc_y_add;
                state <= S_GATE;
              end
              REQ_PRESS: begin
                drag_active <= drag_next;
                rem_x <= '0;
                rem_y <= '0;
                state <= S_OUT;
              end
              REQ_RELEASE: begin
                if (!drag_toggle) begin
                  drag_active <= drag_next;
                  rem_x <= '0;
                  rem_y <= '0;
                end
                state <= S_OUT;
              end
              default: begin
                drag_active <= drag_next;
                acc_x <= '0;
                acc_y <= '0;
                rem_x <= '0;
                rem_y <= '0;
                state <= S_OUT;
              end
            endcase
          end
        end
        // poll gating and the empty check
        S_GATE: begin
          rsp.drag_on <= drag_active;
          if (poll_interval > 8'd1 && elapsed < 16'(poll_interval)) begin
            state <= S_OUT;
          end else begin
            if (poll_interval > 8'd1) begin
              if (elapsed > 16'({poll_interval, 1'b0})) last_poll <= now_q;
              else last_poll <= last_poll + 16'(poll_interval);
            end
            if (acc_x == 32'sd0 && acc_y == 32'sd0) begin
              state <= S_OUT;
            end else begin
              act   <= (acc_x > one32) || (acc_x < -one32) ||
                       (acc_y > one32) || (acc_y < -one32);
              phase <= PH_ROT;
              cnt   <= 2'd0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            case (phase)
              PH_ROT:  state <= S_POST;
              PH_BACK: state <= S_FIX;
              default: state <= S_REM;
            endcase
          end
        end
        // rotated motion into cursor counts or scroll totals
        S_POST: begin
          if (drag_active) begin
            tx      <= rnd_pow2(rx, COEF_FRAC_BITS) + RW'(rem_x);
            ty      <= rnd_pow2(ry, COEF_FRAC_BITS) + RW'(rem_y);
            div_sel <= 1'b0;
            state   <= S_DLOAD;
          end else begin
            sx    <= clamp127(rnd_pow2(rx, ACC_FRAC_BITS + COEF_FRAC_BITS));
            sy    <= clamp127(rnd_pow2(ry, ACC_FRAC_BITS + COEF_FRAC_BITS));
            phase <= PH_BACK;
            cnt   <= 2'd0;
            state <= S_MUL;
          end
        end
        // take the sent amount back out of the accumulators
        S_FIX: begin
          acc_x <= sat32(SW'(acc_x) - SW'(rnd_pow2(bx, COEF_FRAC_BITS)));
          acc_y <= sat32(SW'(acc_y) - SW'(rnd_pow2(by, COEF_FRAC_BITS)));
          rsp.cur_x  <= sx;
          rsp.cur_y  <= sy;
          rsp.active <= act;
          state <= S_OUT;
        end
        S_DLOAD: begin
          dneg  <= dsrc[RW-1];
          num   <= nload;
          dd    <= d2 << 6;
          big   <= nload >= (d2 << 7);
          quo   <= '0;
          dcnt  <= 3'd6;
          state <= S_DIV;
        end
        // restoring quotient, one bit a cycle
        S_DIV: begin
          if (dbit) num <= num - dd;
          dd   <= dd >> 1;
          quo  <= quo_n;
          dcnt <= dcnt - 3'd1;
          if (dcnt == 3'd0) begin
            if (!div_sel) begin
              sv      <= dres;
              div_sel <= 1'b1;
              state   <= S_DLOAD;
            end else begin
              sh    <= dres;
              phase <= PH_REM;
              cnt   <= 2'd0;
              state <= S_MUL;
            end
          end
        end
        S_REM: begin
          rem_y <= sat32(SW'(ty) - SW'(prod[0]));
          rem_x <= sat32(SW'(tx) - SW'(prod[1]));
          acc_x <= '0;
          acc_y <= '0;
          rsp.wheel_v <= sv;
          rsp.wheel_h <= sh;
          rsp.active  <= act;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sim/tb_trackball_motion_rotate_scroll_top.sv]
// Self-checking bench for trackball_motion_rotate_scroll_top: a cycle-free
// predictor of accumulate, poll gating, rotation, cursor and drag scroll.
// Depends on tmrs_pkg, tmrs_chan_if and the top level in design/.
`timescale 1ns / 1ps
module tb_trackball_motion_rotate_scroll_top;
  import tmrs_pkg::*;

  localparam int ACC_FB  = 8;
  localparam int COEF_FB = 14;
  localparam int RAND_ITEMS = 400;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tmrs_chan_if #(.T(req_t)) in_ch();
  tmrs_chan_if #(.T(rsp_t)) out_ch();

  trackball_motion_rotate_scroll_top u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // predictor copy of config and state
  longint m_cos, m_sin;
  int unsigned m_div, m_inv, m_poll, m_toggle;
  longint m_acc_x, m_acc_y, m_rem_x, m_rem_y;
  bit m_drag;
  logic [15:0] m_last_poll;

  rsp_t pending_reports[$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  logic [15:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb_trackball_motion_rotate_scroll_top: FAIL");
    $finish;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp127(longint v);
    if (v > 127) return 127;
    if (v < -127) return -127;
    return v;
  endfunction

  // rounds n/d half away from zero, d > 0
  function automatic longint round_div(longint n, longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag * 2 + d) / (d * 2);
    return (n < 0) ? -q : q;
  endfunction

  function automatic rsp_t zero_rsp();
    rsp_t r;
    r = '0;
    r.drag_on = m_drag;
    return r;
  endfunction

  function automatic rsp_t predict_report(req_t q);
    longint one, rx, ry, dfix, tx, ty, ydir, sv, sh, senty, sx, sy, bx, by;
    logic [15:0] el;
    bit act;
    rsp_t r;
    one = longint'(1) << ACC_FB;
    if (q.req_type == REQ_PRESS || q.req_type == REQ_RELEASE) begin
      if (m_toggle != 0) begin
        if (q.req_type == REQ_PRESS) begin
          m_drag = !m_drag;
          m_rem_x = 0;
          m_rem_y = 0;
        end
      end else begin
        m_drag = (q.req_type == REQ_PRESS);
        m_rem_x = 0;
        m_rem_y = 0;
      end
      return zero_rsp();
    end
    if (q.req_type == REQ_CLEAR) begin
      m_drag = 0;
      m_acc_x = 0; m_acc_y = 0; m_rem_x = 0; m_rem_y = 0;
      return zero_rsp();
    end
    m_acc_x = sat32(m_acc_x + longint'($signed(q.dx)) * one);
    m_acc_y = sat32(m_acc_y + longint'($signed(q.dy)) * one);
    // poll gating
    if (m_poll > 1) begin
      el = q.now_ms - m_last_poll;
      if (el < m_poll) return zero_rsp();
      if (el > m_poll * 2) m_last_poll = q.now_ms;
      else m_last_poll = m_last_poll + 16'(m_poll);
    end
    if (m_acc_x == 0 && m_acc_y == 0) return zero_rsp();
    act = (m_acc_x > one || m_acc_x < -one || m_acc_y > one || m_acc_y < -one);
    rx = m_acc_x * m_cos - m_acc_y * m_sin;
    ry = m_acc_x * m_sin + m_acc_y * m_cos;
    r = zero_rsp();
    r.active = act;
    if (m_drag) begin
      dfix = longint'((m_div != 0) ? m_div : 1) << ACC_FB;
      tx = round_div(rx, longint'(1) << COEF_FB) + m_rem_x;
      ty = round_div(ry, longint'(1) << COEF_FB) + m_rem_y;
      ydir = (m_inv != 0) ? ty : -ty;
      sv = clamp127(round_div(ydir, dfix));
      sh = clamp127(round_div(tx, dfix));
      senty = (m_inv != 0) ? sv : -sv;
      m_rem_y = sat32(ty - senty * dfix);
      m_rem_x = sat32(tx - sh * dfix);
      m_acc_x = 0;
      m_acc_y = 0;
      r.wheel_v = 8'(sv);
      r.wheel_h = 8'(sh);
    end else begin
      sx = clamp127(round_div(rx, longint'(1) << (ACC_FB + COEF_FB)));
      sy = clamp127(round_div(ry, longint'(1) << (ACC_FB + COEF_FB)));
      bx = (sx * m_cos + sy * m_sin) * one;
      by = (sy * m_cos - sx * m_sin) * one;
      m_acc_x = sat32(m_acc_x - round_div(bx, longint'(1) << COEF_FB));
      m_acc_y = sat32(m_acc_y - round_div(by, longint'(1) << COEF_FB));
      r.cur_x = 8'(sx);
      r.cur_y = 8'(sy);
    end
    return r;
  endfunction

  // receiver: random stall, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected word %p", $time, out_ch.data);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.data !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, out_ch.data);
          errors++;
        end
      end
    end
  end

  // offers one word and waits for the handshake; expectation pushed at accept
  task automatic send_word(req_t q, bit typed, rsp_t typed_rsp);
    rsp_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= q;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    p = predict_report(q);
    pending_reports.push_back(typed ? typed_rsp : p);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= 16'(val);
    @(posedge clk);
    case (idx)
      CFG_ROT_COS:     m_cos = longint'($signed(16'(val)));
      CFG_ROT_SIN:     m_sin = longint'($signed(16'(val)));
      CFG_SCROLL_DIV:  m_div = val & 8'hff;
      CFG_INVERT_V:    m_inv = val & 1;
      CFG_POLL_INTV:   m_poll = val & 8'hff;
      CFG_DRAG_TOGGLE: m_toggle = val & 1;
      default: ;
    endcase
  endtask

  task automatic setup(int c, int s, int dv, int inv, int poll, int tog);
    drain();
    write_reg(CFG_ROT_COS, c);
    write_reg(CFG_ROT_SIN, s);
    write_reg(CFG_SCROLL_DIV, dv);
    write_reg(CFG_INVERT_V, inv);
    write_reg(CFG_POLL_INTV, poll);
    write_reg(CFG_DRAG_TOGGLE, tog);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_delta();
    int k;
    k = $urandom_range(9);
    if (k < 6) return 16'($signed($urandom_range(40)) - 20);
    if (k < 8) return 16'($urandom);
    return (k == 8) ? 16'h7fff : 16'h8000;
  endfunction

  // random word: mostly motion with advancing time, some drag and clear
  function automatic req_t rand_word();
    req_t q;
    int k;
    k = $urandom_range(99);
    q.dx = rand_delta();
    q.dy = rand_delta();
    if (k < 8) q.req_type = REQ_PRESS;
    else if (k < 15) q.req_type = REQ_RELEASE;
    else if (k < 18) q.req_type = REQ_CLEAR;
    else q.req_type = REQ_MOTION;
    if ($urandom_range(19) == 0) clock_ms = 16'($urandom);
    else clock_ms = clock_ms + 16'($urandom_range(m_poll * 3 + 1));
    q.now_ms = clock_ms;
    return q;
  endfunction

  typedef struct {
    req_t q;
    bit   typed;
    rsp_t r;
  } stim_row_t;

  stim_row_t stim_rows[$];

  function automatic stim_row_t row(logic [1:0] t, int dx, int dy, int ms,
                                    bit typed, rsp_t r);
    stim_row_t s;
    s.q.req_type = t;
    s.q.dx = 16'(dx);
    s.q.dy = 16'(dy);
    s.q.now_ms = 16'(ms);
    s.typed = typed;
    s.r = r;
    return s;
  endfunction

  function automatic rsp_t mk(int cx, int cy, bit act, bit drag);
    rsp_t r;
    r = '0;
    r.cur_x = 8'(cx);
    r.cur_y = 8'(cy);
    r.active = act;
    r.drag_on = drag;
    return r;
  endfunction

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    clock_ms = '0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    m_cos = 16384; m_sin = 0; m_div = 8; m_inv = 0; m_poll = 1; m_toggle = 0;
    m_acc_x = 0; m_acc_y = 0; m_rem_x = 0; m_rem_y = 0;
    m_drag = 0; m_last_poll = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset defaults, extremes, drag and clear
    stim_rows.push_back(row(REQ_MOTION, 0, 0, 0, 1, mk(0, 0, 0, 0)));
    stim_rows.push_back(row(REQ_CLEAR, 5, 5, 1, 1, mk(0, 0, 0, 0)));
    stim_rows.push_back(row(REQ_MOTION, 1, 0, 2, 1, mk(1, 0, 0, 0)));
    stim_rows.push_back(row(REQ_MOTION, 32767, 0, 3, 1, mk(127, 0, 1, 0)));
    stim_rows.push_back(row(REQ_MOTION, -32768, 32767, 4, 0, '0));
    stim_rows.push_back(row(REQ_MOTION, 32767, -32768, 5, 0, '0));
    stim_rows.push_back(row(REQ_MOTION, -1, -1, 6, 0, '0));
    stim_rows.push_back(row(REQ_CLEAR, 0, 0, 7, 1, mk(0, 0, 0, 0)));
    stim_rows.push_back(row(REQ_PRESS, 0, 0, 8, 1, mk(0, 0, 0, 1)));
    stim_rows.push_back(row(REQ_MOTION, 0, -100, 9, 0, '0));
    stim_rows.push_back(row(REQ_MOTION, 3, 5, 10, 0, '0));
    stim_rows.push_back(row(REQ_MOTION, -32768, -32768, 11, 0, '0));
    stim_rows.push_back(row(REQ_MOTION, 32767, 32767, 12, 0, '0));
    stim_rows.push_back(row(REQ_PRESS, 0, 0, 13, 1, mk(0, 0, 0, 1)));
    stim_rows.push_back(row(REQ_RELEASE, 0, 0, 14, 1, mk(0, 0, 0, 0)));
    stim_rows.push_back(row(REQ_PRESS, 0, 0, 15, 0, '0));
    stim_rows.push_back(row(REQ_CLEAR, 0, 0, 16, 1, mk(0, 0, 0, 0)));
    // long hold-off while words keep coming
    hold_cycles = 300;
    foreach (stim_rows[i]) send_word(stim_rows[i].q, stim_rows[i].typed, stim_rows[i].r);

    // random phases across settings and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: setup(16384, 0, 8, 0, 1, 0);
        1: setup(-16384, 0, 0, 1, 4, 1);
        2: setup(11585, 11585, 1, 0, 2, 0);
        3: setup(0, -16384, 255, 1, 255, 1);
        4: setup(-11585, 11585, 3, 1, 1, 0);
        5: setup(16384, 16384, 128, 0, 3, 1);
        6: setup(-16384, -16384, 2, 1, 0, 0);
        default: setup(15137, -6270, 16, 0, 1, 1);
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (ph == 2) hold_cycles = 400;
      for (int n = 0; n < RAND_ITEMS / 8; n++) send_word(rand_word(), 0, '0);
    end

    drain();
    if (errors == 0) begin
      $display("tb_trackball_motion_rotate_scroll_top: PASS");
    end else begin
      $display("tb_trackball_motion_rotate_scroll_top: FAIL");
    end
    $finish;
  end
endmodule
